// File: rtl/ttat_pkg.sv
// Shared types and codes for the timed alarm table.
package ttat_pkg;

  typedef enum logic [1:0] {
    CMD_ADD_DAILY = 2'd0,
    CMD_ADD_ONCE  = 2'd1,
    CMD_REMOVE    = 2'd2,
    CMD_TICK      = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    RC_ADDED     = 3'd0,
    RC_FULL      = 3'd1,
    RC_REMOVED   = 3'd2,
    RC_NOT_FOUND = 3'd3,
    RC_FIRED     = 3'd4,
    RC_IDLE      = 3'd5
  } rc_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input item
    logic append;      // write a new entry at the end of the table
    logic scan_clr;    // reset the scan index to zero
    logic scan_inc;    // step the scan index
    logic shift;       // copy entry index+1 to index (compaction step)
    logic dec_count;   // one entry fewer
    logic seen_upd;    // take the captured clock as the seen clock
    logic emit;        // drive a result this cycle
    rc_e  emit_code;
    logic emit_id;     // result carries the scanned entry id
    logic emit_new_id; // result carries the freshly assigned id
    logic emit_kind;
    logic emit_last;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic scan_end;     // scan index at or past the entry count
    logic shift_end;    // scan index is the last valid place
    logic id_hit;
    logic daily_hit;
    logic once_hit;
    logic clock_new;    // tick clock valid and unlike the seen clock
  } stat_t;

endpackage

// File: rtl/ttat_datapath.sv
// Datapath of the alarm table: entry storage, scan index and result drive.
module ttat_datapath #(
  parameter int unsigned TableDepth = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ttat_pkg::ctrl_t            ctrl_i,
  output ttat_pkg::stat_t            stat_o,
  input  logic [1:0]                 command_i,
  input  logic [4:0]                 hour_i,
  input  logic [5:0]                 minute_i,
  input  logic [5:0]                 second_i,
  input  logic [31:0]                delay_ms_i,
  input  logic [15:0]                target_id_i,
  input  logic [31:0]                now_ms_i,
  input  logic                       time_valid_i,
  output logic                       result_valid_o,
  output logic [2:0]                 result_code_o,
  output logic [15:0]                task_id_o,
  output logic                       fired_kind_o,
  output logic                       last_o
);
  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  typedef struct packed {
    logic [15:0] id;
    logic        kind;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [31:0] deadline;
  } entry_t;

  entry_t           tab_q [TableDepth];
  logic [CntW-1:0]  count_q;
  logic [15:0]      next_id_q;
  logic [CntW-1:0]  idx_q;
  logic [1:0]       cmd_q;
  logic [4:0]       hour_q;
  logic [5:0]       minute_q, second_q;
  logic [31:0]      dl_q, now_q;
  logic [15:0]      target_q;
  logic             tvalid_q;
  logic             seen_valid_q;
  logic [4:0]       seen_hour_q;
  logic [5:0]       seen_minute_q, seen_second_q;

  entry_t           cur;
  entry_t           nxt;
  logic [IdxW-1:0]  idx_w;
  logic [IdxW-1:0]  idx_n;
  logic [CntW-1:0]  idx_p1;

  assign idx_w  = idx_q[IdxW-1:0];
  assign idx_p1 = idx_q + CntW'(1);
  assign idx_n  = (idx_p1 < CntW'(TableDepth)) ? idx_p1[IdxW-1:0] : idx_w;
  assign cur    = tab_q[idx_w];
  assign nxt    = tab_q[idx_n];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      next_id_q    <= 16'd1;
      idx_q        <= '0;
      seen_valid_q <= 1'b0;
      seen_hour_q  <= '0;
      seen_minute_q <= '0;
      seen_second_q <= '0;
    end else begin
      if (ctrl_i.scan_clr) begin
        idx_q <= '0;
      end else if (ctrl_i.scan_inc) begin
        idx_q <= idx_p1;
      end
      if (ctrl_i.append) begin
        count_q   <= count_q + CntW'(1);
        next_id_q <= (next_id_q == 16'hFFFF) ? 16'd1 : next_id_q + 16'd1;
      end else if (ctrl_i.dec_count) begin
        count_q <= count_q - CntW'(1);
      end
      if (ctrl_i.seen_upd) begin
        seen_valid_q  <= 1'b1;
        seen_hour_q   <= hour_q;
        seen_minute_q <= minute_q;
        seen_second_q <= second_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q    <= command_i;
      hour_q   <= hour_i;
      minute_q <= minute_i;
      second_q <= second_i;
      dl_q     <= now_ms_i + delay_ms_i;
      now_q    <= now_ms_i;
      target_q <= target_id_i;
      tvalid_q <= time_valid_i;
    end
    if (ctrl_i.append) begin
      tab_q[count_q[IdxW-1:0]] <= '{
        id:       next_id_q,
        kind:     (cmd_q == ttat_pkg::CMD_ADD_ONCE),
        hour:     (cmd_q == ttat_pkg::CMD_ADD_ONCE) ? 5'd0 : hour_q,
        minute:   (cmd_q == ttat_pkg::CMD_ADD_ONCE) ? 6'd0 : minute_q,
        second:   (cmd_q == ttat_pkg::CMD_ADD_ONCE) ? 6'd0 : second_q,
        deadline: (cmd_q == ttat_pkg::CMD_ADD_ONCE) ? dl_q : 32'd0
      };
    end
    if (ctrl_i.shift) begin
      tab_q[idx_w] <= nxt;
    end
  end

  always_comb begin
    stat_o.cmd       = ttat_pkg::cmd_e'(cmd_q);
    stat_o.full      = (count_q >= CntW'(TableDepth));
    stat_o.scan_end  = (idx_q >= count_q);
    stat_o.shift_end = (idx_p1 >= count_q);
    stat_o.id_hit    = (cur.id == target_q);
    stat_o.daily_hit = !cur.kind && cur.hour == hour_q && cur.minute == minute_q
                       && cur.second == second_q;
    stat_o.once_hit  = cur.kind && (now_q >= cur.deadline);
    stat_o.clock_new = tvalid_q && !(seen_valid_q && seen_hour_q == hour_q
                       && seen_minute_q == minute_q && seen_second_q == second_q);
  end

  always_comb begin
    result_valid_o = ctrl_i.emit;
    result_code_o  = ctrl_i.emit_code;
    task_id_o      = ctrl_i.emit_id ? cur.id : (ctrl_i.emit_new_id ? next_id_q : 16'd0);
    fired_kind_o   = ctrl_i.emit_kind;
    last_o         = ctrl_i.emit_last;
  end

endmodule

// File: rtl/ttat_ctrl.sv
// Controller state machine sequencing the alarm table commands.
module ttat_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  ttat_pkg::stat_t   stat_i,
  output ttat_pkg::ctrl_t   ctrl_o
);
  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DECODE  = 8'b0000_0010,
    S_FIND    = 8'b0000_0100,
    S_COMPACT = 8'b0000_1000,
    S_DAILY   = 8'b0001_0000,
    S_ONCE    = 8'b0010_0000,
    S_OCOMP   = 8'b0100_0000,
    S_OLAST   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   fired_q, fired_d;

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fired_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fired_q <= fired_d;
    end
  end

  always_comb begin
    state_d = state_q;
    fired_d = fired_q;
    ctrl_o  = '0;
    ctrl_o.emit_code = ttat_pkg::RC_IDLE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctrl_o.load = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        ctrl_o.scan_clr = 1'b1;
        fired_d = 1'b0;
        case (stat_i.cmd)
          ttat_pkg::CMD_ADD_DAILY, ttat_pkg::CMD_ADD_ONCE: begin
            ctrl_o.emit = 1'b1;
            ctrl_o.emit_last = 1'b1;
            if (stat_i.full) begin
              ctrl_o.emit_code = ttat_pkg::RC_FULL;
            end else begin
              ctrl_o.emit_code = ttat_pkg::RC_ADDED;
              ctrl_o.emit_new_id = 1'b1;
              ctrl_o.append = 1'b1;
            end
            state_d = S_IDLE;
          end
          ttat_pkg::CMD_REMOVE: state_d = S_FIND;
          default: begin
            if (stat_i.clock_new) begin
              ctrl_o.seen_upd = 1'b1;
              state_d = S_DAILY;
            end else begin
              state_d = S_ONCE;
            end
          end
        endcase
      end
      S_FIND: begin
        if (stat_i.scan_end) begin
          ctrl_o.emit = 1'b1;
          ctrl_o.emit_last = 1'b1;
          ctrl_o.emit_code = ttat_pkg::RC_NOT_FOUND;
          state_d = S_IDLE;
        end else if (stat_i.id_hit) begin
          state_d = S_COMPACT;
        end else begin
          ctrl_o.scan_inc = 1'b1;
        end
      end
      S_COMPACT: begin
        if (stat_i.shift_end) begin
          ctrl_o.dec_count = 1'b1;
          ctrl_o.emit = 1'b1;
          ctrl_o.emit_last = 1'b1;
          ctrl_o.emit_code = ttat_pkg::RC_REMOVED;
          state_d = S_IDLE;
        end else begin
          ctrl_o.shift = 1'b1;
          ctrl_o.scan_inc = 1'b1;
        end
      end
      S_DAILY: begin
        if (stat_i.scan_end) begin
          ctrl_o.scan_clr = 1'b1;
          state_d = S_ONCE;
        end else begin
          ctrl_o.scan_inc = 1'b1;
          if (stat_i.daily_hit) begin
            ctrl_o.emit = 1'b1;
            ctrl_o.emit_code = ttat_pkg::RC_FIRED;
            ctrl_o.emit_id = 1'b1;
            fired_d = 1'b1;
          end
        end
      end
      S_ONCE: begin
        if (stat_i.scan_end) begin
          ctrl_o.emit = 1'b1;
          ctrl_o.emit_last = 1'b1;
          ctrl_o.emit_code = ttat_pkg::RC_IDLE;
          state_d = S_IDLE;
        end else if (stat_i.once_hit) begin
          ctrl_o.emit = 1'b1;
          ctrl_o.emit_code = ttat_pkg::RC_FIRED;
          ctrl_o.emit_id = 1'b1;
          ctrl_o.emit_kind = 1'b1;
          fired_d = 1'b1;
          state_d = S_OCOMP;
        end else begin
          ctrl_o.scan_inc = 1'b1;
        end
      end
      S_OCOMP: begin
        // Close the gap left by a fired one-shot, then walk again from the head.
        if (stat_i.shift_end) begin
          ctrl_o.dec_count = 1'b1;
          state_d = S_OLAST;
        end else begin
          ctrl_o.shift = 1'b1;
          ctrl_o.scan_inc = 1'b1;
        end
      end
      S_OLAST: begin
        ctrl_o.scan_clr = 1'b1;
        state_d = S_ONCE;
      end
      default: state_d = S_IDLE;
    endcase
    // The final result of a tick: an empty closing result only if nothing fired.
    if (state_q == S_ONCE && stat_i.scan_end && fired_q) begin
      ctrl_o.emit = 1'b0;
    end
  end

endmodule

// File: rtl/timed_task_alarm_table.sv
// Top level of the timed alarm table: controller plus datapath.
//
// The block holds an ordered table of up to TABLE_DEPTH alarms, daily or
// one-shot, and takes an item when start is high and busy is low. An add
// answers in the cycle right after it is taken, and the next item can be
// taken in the cycle after the answer. Remove scans for the id and then
// compacts the table. A tick walks the table once for daily matches and then
// for due one-shot alarms; each fired one-shot is compacted and the one-shot
// walk restarts from the head, so a tick runs longest when many one-shots
// fire; the table walk and compaction loop set this.
// Results appear on result_valid_o for one cycle each and cannot be held off;
// last_o marks the final result of an item. A tick where alarms fired ends with
// a last result that is the final fired alarm, so the top level holds each
// fired result back until the next result of the tick is known; see result
// staging below.
module timed_task_alarm_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [4:0]  hour_i,
  input  logic [5:0]  minute_i,
  input  logic [5:0]  second_i,
  input  logic [31:0] delay_ms_i,
  input  logic [15:0] target_id_i,
  input  logic [31:0] now_ms_i,
  input  logic        time_valid_i,
  output logic        result_valid_o,
  output logic [2:0]  result_code_o,
  output logic [15:0] task_id_o,
  output logic        fired_kind_o,
  output logic        last_o
);
  ttat_pkg::ctrl_t ctrl;
  ttat_pkg::stat_t stat;
  logic            ctrl_busy;
  logic            dp_valid, dp_last, dp_kind;
  logic [2:0]      dp_code;
  logic [15:0]     dp_id;

  // One-deep staging: a result is held until the next one arrives, so the
  // held result can be marked last when the item's final result comes in.
  logic            hold_q;
  logic [2:0]      hcode_q;
  logic [15:0]     hid_q;
  logic            hkind_q;
  logic            flush;

  ttat_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (ctrl_busy),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  ttat_datapath #(.TableDepth(TABLE_DEPTH)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .command_i     (command_i),
    .hour_i        (hour_i),
    .minute_i      (minute_i),
    .second_i      (second_i),
    .delay_ms_i    (delay_ms_i),
    .target_id_i   (target_id_i),
    .now_ms_i      (now_ms_i),
    .time_valid_i  (time_valid_i),
    .result_valid_o(dp_valid),
    .result_code_o (dp_code),
    .task_id_o     (dp_id),
    .fired_kind_o  (dp_kind),
    .last_o        (dp_last)
  );

  // A tick that fired ends with the suppressed closing result; that end flushes
  // the held firing as last.
  assign flush = ctrl_busy && !dp_valid && ctrl.emit_last && hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else if (dp_valid && !dp_last) begin
      hold_q <= 1'b1;
    end else if (dp_valid || flush) begin
      hold_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_valid && !dp_last) begin
      hcode_q <= dp_code;
      hid_q   <= dp_id;
      hkind_q <= dp_kind;
    end
  end

  always_comb begin
    result_valid_o = 1'b0;
    result_code_o  = dp_code;
    task_id_o      = dp_id;
    fired_kind_o   = dp_kind;
    last_o         = 1'b0;
    if (hold_q && (dp_valid || flush)) begin
      result_valid_o = 1'b1;
      result_code_o  = hcode_q;
      task_id_o      = hid_q;
      fired_kind_o   = hkind_q;
      last_o         = flush;
    end else if (dp_valid && dp_last) begin
      result_valid_o = 1'b1;
      last_o         = 1'b1;
    end
  end

  assign busy = ctrl_busy || hold_q;

  // Only fired results of a tick are held. A fresh final result never meets a
  // held one, because a tick that fired suppresses its closing result and the
  // held firing goes out as last in that cycle instead.

  a_last_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !hold_q)
    else $error("held result survived the final result");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("item taken without going busy");
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_code_o <= 3'd5))
    else $error("result code out of range");

endmodule

// File: tb/timed_task_alarm_table_checker.sv
// Checker for the timed alarm table: predicts results of accepted items and compares them.
module timed_task_alarm_table_checker #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  command_i,
  input  logic [4:0]  hour_i,
  input  logic [5:0]  minute_i,
  input  logic [5:0]  second_i,
  input  logic [31:0] delay_ms_i,
  input  logic [15:0] target_id_i,
  input  logic [31:0] now_ms_i,
  input  logic        time_valid_i,
  input  logic        result_valid_o,
  input  logic [2:0]  result_code_o,
  input  logic [15:0] task_id_o,
  input  logic        fired_kind_o,
  input  logic        last_o,
  output int          fail_cnt,
  output int          pending_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    ttat_pkg::rc_e code;
    logic [15:0]   id;
    logic          kind;
    logic          last;
  } alarm_result_t;

  alarm_result_t result_q[$];

  // Shadow copy of the alarm table.
  int unsigned alarm_cnt;
  logic [15:0] id_next;
  logic [15:0] alarm_id[TABLE_DEPTH];
  logic        alarm_once[TABLE_DEPTH];
  logic [4:0]  alarm_hour[TABLE_DEPTH];
  logic [5:0]  alarm_min[TABLE_DEPTH];
  logic [5:0]  alarm_sec[TABLE_DEPTH];
  logic [31:0] alarm_dead[TABLE_DEPTH];
  logic        clk_seen;
  logic [4:0]  seen_h;
  logic [5:0]  seen_m;
  logic [5:0]  seen_s;

  assign pending_cnt = result_q.size();

  function automatic void push_result(ttat_pkg::rc_e code, logic [15:0] id, logic kind);
    alarm_result_t r;
    r.code = code;
    r.id   = id;
    r.kind = kind;
    r.last = 1'b0;
    result_q.push_back(r);
  endfunction

  function automatic void drop_alarm(int unsigned pos);
    for (int unsigned j = pos; j + 1 < alarm_cnt; j++) begin
      alarm_id[j]   = alarm_id[j+1];
      alarm_once[j] = alarm_once[j+1];
      alarm_hour[j] = alarm_hour[j+1];
      alarm_min[j]  = alarm_min[j+1];
      alarm_sec[j]  = alarm_sec[j+1];
      alarm_dead[j] = alarm_dead[j+1];
    end
    alarm_cnt--;
  endfunction

  // Works out every result that one accepted item causes.
  function automatic void predict_alarms(ttat_pkg::cmd_e cmd, logic [4:0] h,
                                         logic [5:0] m, logic [5:0] s,
                                         logic [31:0] dly, logic [15:0] tgt,
                                         logic [31:0] now, logic tv);
    int unsigned i;
    int unsigned base;
    bit          found;
    base  = result_q.size();
    found = 0;
    case (cmd)
      ttat_pkg::CMD_ADD_DAILY, ttat_pkg::CMD_ADD_ONCE: begin
        if (alarm_cnt >= TABLE_DEPTH) begin
          push_result(ttat_pkg::RC_FULL, '0, 1'b0);
        end else begin
          alarm_id[alarm_cnt]   = id_next;
          alarm_once[alarm_cnt] = (cmd == ttat_pkg::CMD_ADD_ONCE);
          alarm_hour[alarm_cnt] = (cmd == ttat_pkg::CMD_ADD_DAILY) ? h : '0;
          alarm_min[alarm_cnt]  = (cmd == ttat_pkg::CMD_ADD_DAILY) ? m : '0;
          alarm_sec[alarm_cnt]  = (cmd == ttat_pkg::CMD_ADD_DAILY) ? s : '0;
          alarm_dead[alarm_cnt] = (cmd == ttat_pkg::CMD_ADD_ONCE) ? now + dly : '0;
          alarm_cnt++;
          push_result(ttat_pkg::RC_ADDED, id_next, 1'b0);
          id_next = (id_next == 16'hFFFF) ? 16'd1 : id_next + 16'd1;
        end
      end
      ttat_pkg::CMD_REMOVE: begin
        for (i = 0; i < alarm_cnt && !found; i++) begin
          if (alarm_id[i] == tgt) begin
            drop_alarm(i);
            found = 1;
          end
        end
        push_result(found ? ttat_pkg::RC_REMOVED : ttat_pkg::RC_NOT_FOUND, '0, 1'b0);
      end
      default: begin
        // Daily alarms are only checked when a valid clock differs from the last one seen.
        if (tv && !(clk_seen && seen_h == h && seen_m == m && seen_s == s)) begin
          clk_seen = 1'b1;
          seen_h   = h;
          seen_m   = m;
          seen_s   = s;
          for (i = 0; i < alarm_cnt; i++) begin
            if (!alarm_once[i] && alarm_hour[i] == h && alarm_min[i] == m &&
                alarm_sec[i] == s) begin
              push_result(ttat_pkg::RC_FIRED, alarm_id[i], 1'b0);
            end
          end
        end
        // Due one-shot alarms fire and leave the table, which closes up.
        i = 0;
        while (i < alarm_cnt) begin
          if (alarm_once[i] && now >= alarm_dead[i]) begin
            push_result(ttat_pkg::RC_FIRED, alarm_id[i], 1'b1);
            drop_alarm(i);
          end else begin
            i++;
          end
        end
        if (result_q.size() == base) begin
          push_result(ttat_pkg::RC_IDLE, '0, 1'b0);
        end
      end
    endcase
    result_q[result_q.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alarm_result_t want;
    if (!rst_ni) begin
      alarm_cnt = 0;
      id_next   = 16'd1;
      clk_seen  = 1'b0;
      seen_h    = '0;
      seen_m    = '0;
      seen_s    = '0;
      fail_cnt <= 0;
      result_q.delete();
    end else begin
      // Results are compared before the new item is predicted; an item taken
      // at this edge cannot have a result at the same edge anyway.
      if (result_valid_o) begin
        if (result_q.size() == 0) begin
          if (fail_cnt < 10) begin
            $display("%0t: result with nothing expected: code %0d id %0d kind %0d last %0d",
                     $realtime, result_code_o, task_id_o, fired_kind_o, last_o);
          end
          fail_cnt <= fail_cnt + 1;
        end else begin
          want = result_q.pop_front();
          if (result_code_o !== want.code || task_id_o !== want.id ||
              fired_kind_o !== want.kind || last_o !== want.last) begin
            if (fail_cnt < 10) begin
              $display({"%0t: mismatch: expected code %0d id %0d kind %0d last %0d,",
                        " got %0d %0d %0d %0d"},
                       $realtime, want.code, want.id, want.kind, want.last,
                       result_code_o, task_id_o, fired_kind_o, last_o);
            end
            fail_cnt <= fail_cnt + 1;
          end
        end
      end
      if (start && !busy) begin
        predict_alarms(ttat_pkg::cmd_e'(command_i), hour_i, minute_i, second_i,
                       delay_ms_i, target_id_i, now_ms_i, time_valid_i);
      end
    end
  end

endmodule

// File: tb/timed_task_alarm_table_tb.sv
// Testbench top for the timed alarm table: stimulus, clock, reset and verdict.
module timed_task_alarm_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command_i = ttat_pkg::CMD_TICK;
  logic [4:0]  hour_i = '0;
  logic [5:0]  minute_i = '0;
  logic [5:0]  second_i = '0;
  logic [31:0] delay_ms_i = '0;
  logic [15:0] target_id_i = '0;
  logic [31:0] now_ms_i = '0;
  logic        time_valid_i = 1'b0;
  logic        result_valid_o;
  logic [2:0]  result_code_o;
  logic [15:0] task_id_o;
  logic        fired_kind_o;
  logic        last_o;
  int          fail_cnt;
  int          pending_cnt;
  int unsigned cycle_cnt = 0;

  // Stimulus state: a running millisecond clock and a rough count of ids
  // handed out, so that removes mostly aim at alarms that exist.
  logic [31:0] clock_ms = 32'd5000;
  int unsigned adds_sent = 0;
  bit          gaps_on = 1'b1;

  always #6 clk_i = ~clk_i;

  timed_task_alarm_table i_dut (.*);

  timed_task_alarm_table_checker i_checker (.*);

  // Generous watchdog, far above long ticks back to back for every item.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timed_task_alarm_table regression: fail");
      $finish;
    end
  end

  // Presents one item and holds it until the block takes it, then maybe
  // leaves a random gap. start stays high between back-to-back items.
  task automatic send_item(ttat_pkg::cmd_e cmd, logic [4:0] h, logic [5:0] m,
                           logic [5:0] s, logic [31:0] dly, logic [15:0] tgt,
                           logic [31:0] now, logic tv);
    int unsigned gap;
    start        <= 1'b1;
    command_i    <= cmd;
    hour_i       <= h;
    minute_i     <= m;
    second_i     <= s;
    delay_ms_i   <= dly;
    target_id_i  <= tgt;
    now_ms_i     <= now;
    time_valid_i <= tv;
    do @(posedge clk_i); while (busy);
    if (cmd == ttat_pkg::CMD_ADD_DAILY || cmd == ttat_pkg::CMD_ADD_ONCE) adds_sent++;
    if (gaps_on && $urandom_range(99) < 38) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // One random item. Clock fields mostly come from a small set so that daily
  // alarms really match, and the time mostly moves forward.
  task automatic send_random_item();
    ttat_pkg::cmd_e cmd;
    logic [4:0]     h;
    logic [5:0]     m;
    logic [5:0]     s;
    logic [31:0]    dly;
    logic [15:0]    tgt;
    logic [31:0]    now;
    int unsigned    pick;
    pick = $urandom_range(99);
    cmd  = pick < 25 ? ttat_pkg::CMD_ADD_DAILY : pick < 50 ? ttat_pkg::CMD_ADD_ONCE :
           pick < 65 ? ttat_pkg::CMD_REMOVE : ttat_pkg::CMD_TICK;
    if ($urandom_range(9) == 0) begin
      h = 5'($urandom);
      m = 6'($urandom);
      s = 6'($urandom);
    end else begin
      h = 5'($urandom_range(1));
      m = 6'($urandom_range(1));
      s = 6'($urandom_range(2));
    end
    dly = ($urandom_range(9) == 0) ? $urandom : $urandom_range(400);
    if ($urandom_range(9) == 0) tgt = 16'($urandom);
    else tgt = 16'(adds_sent + 1 - $urandom_range(adds_sent < 20 ? adds_sent : 20));
    clock_ms += $urandom_range(150);
    now = ($urandom_range(19) == 0) ? $urandom : clock_ms;
    send_item(cmd, h, m, s, dly, tgt, now, $urandom_range(99) < 80);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part: empty table, extremes of the fields, table full,
    // repeated clock second, invalid clock, deadline that wraps.
    send_item(ttat_pkg::CMD_TICK, 5'd0, 6'd0, 6'd0, '0, '0, 32'd0, 1'b0);
    send_item(ttat_pkg::CMD_REMOVE, '0, '0, '0, '0, 16'd0, '0, 1'b0);
    send_item(ttat_pkg::CMD_ADD_DAILY, 5'd23, 6'd59, 6'd59, '0, '0, '0, 1'b0);
    send_item(ttat_pkg::CMD_ADD_DAILY, 5'd0, 6'd0, 6'd0, '1, '1, '1, 1'b1);
    send_item(ttat_pkg::CMD_ADD_DAILY, 5'd31, 6'd63, 6'd63, '0, '0, '0, 1'b0);
    send_item(ttat_pkg::CMD_ADD_ONCE, '1, '1, '1, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, 1'b1);
    send_item(ttat_pkg::CMD_ADD_ONCE, '0, '0, '0, 32'd0, '0, 32'd100, 1'b0);
    send_item(ttat_pkg::CMD_TICK, 5'd23, 6'd59, 6'd59, '0, '0, 32'd99, 1'b1);
    send_item(ttat_pkg::CMD_TICK, 5'd23, 6'd59, 6'd59, '0, '0, 32'd100, 1'b1);
    send_item(ttat_pkg::CMD_TICK, 5'd0, 6'd0, 6'd0, '0, '0, 32'd0, 1'b0);
    send_item(ttat_pkg::CMD_TICK, 5'd31, 6'd63, 6'd63, '0, '0, 32'hFFFF_FFFF, 1'b1);
    send_item(ttat_pkg::CMD_REMOVE, '0, '0, '0, '0, 16'd2, '0, 1'b0);
    send_item(ttat_pkg::CMD_REMOVE, '0, '0, '0, '0, 16'd2, '0, 1'b0);
    send_item(ttat_pkg::CMD_REMOVE, '0, '0, '0, '0, 16'hFFFF, '0, 1'b0);
    // Two daily alarms remain; fill the table and overflow it once.
    for (int i = 0; i < 15; i++) begin
      send_item(ttat_pkg::CMD_ADD_ONCE, '0, '0, '0, 32'(10 + i), '0, 32'd1000, 1'b0);
    end
    // A single tick now fires fourteen one-shot alarms.
    send_item(ttat_pkg::CMD_TICK, 5'd0, 6'd0, 6'd0, '0, '0, 32'd2000, 1'b0);

    // Random part, with one stretch of back-to-back items in the middle.
    for (int i = 0; i < 300; i++) begin
      gaps_on = !(i >= 120 && i < 180);
      send_random_item();
    end

    // Let the block drain completely before the last few items.
    start <= 1'b0;
    while (pending_cnt != 0) @(posedge clk_i);
    repeat ($urandom_range(1, 20)) @(posedge clk_i);

    gaps_on = 1'b1;
    for (int i = 0; i < 20; i++) send_random_item();
    start <= 1'b0;

    while (pending_cnt != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("timed_task_alarm_table regression: pass");
    end else begin
      $display("timed_task_alarm_table regression: fail");
    end
    $finish;
  end

endmodule
